FILE: rtl/core/linear_probe_hash_table_defines.svh
// Assertion macros shared by the checker of the linear probing hash table.
// Stand-alone header; the only macros used are the ones defined here.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define LPHT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/lpht_pkg.sv
// Shared types and constants for the linear probing hash table.
// No dependencies; used by the top level and by the checker.
package lpht_pkg;

	localparam int KEY_W     = 31;
	localparam int OPCODE_W  = 2;
	localparam int STATUS_W  = 3;
	localparam int IDX_W     = 4;
	localparam int MARK_W    = 2;
	localparam int SLOT_W    = MARK_W + KEY_W;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_DELETE = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_FULL     = 3'd1,
		ST_FOUND    = 3'd2,
		ST_MISSING  = 3'd3,
		ST_DELETED  = 3'd4
	} status_t;

	typedef enum logic [MARK_W-1:0] {
		MARK_FREE = 2'd0,
		MARK_USED = 2'd1,
		MARK_GONE = 2'd2
	} mark_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_ISSUE,
		S_PROBE,
		S_DONE
	} state_t;

	// One table entry as stored in the slot memory.
	typedef struct packed {
		logic [MARK_W-1:0] mark;
		logic [KEY_W-1:0]  key;
	} slot_t;

endpackage

FILE: rtl/core/lpht_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lpht_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/linear_probe_hash_table.sv
// Linear probing hash table: top level with the control sequencer.
// Depends on lpht_pkg and on lpht_ram for the slot memory.
//
// Usage: one request beat on the input channel (opcode, key) gives exactly one
// result beat on the output channel (status, slot_index). Both channels use
// valid/ready. Requests are handled one at a time; in_ready is high only while
// the sequencer is idle, but a result waiting in the output register does not
// block the next request.
// A request goes from S_IDLE through S_ISSUE and S_PROBE to S_DONE; when SLOTS
// is not a power of two it passes S_DIV first (key modulo SLOTS by a reciprocal
// multiply). Invalid opcodes go from S_IDLE straight to S_DONE. The probe reads
// one slot per cycle from the slot memory and visits at most SLOTS slots per
// request. After reset the block walks the memory once to mark every slot
// free; in_ready stays low until the walk is done.
// When the receiver stalls, the result holds in the output register; a new
// request may still run, and it waits at its end until the register is free.
module linear_probe_hash_table #(
	parameter int SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lpht_pkg::OPCODE_W-1:0] opcode,
	input  logic [lpht_pkg::KEY_W-1:0]    key,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lpht_pkg::STATUS_W-1:0] status,
	output logic [lpht_pkg::IDX_W-1:0]    slot_index
);

	import lpht_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
	localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);
	localparam logic [AW-1:0] SLOTS_LO = AW'(SLOTS);
	localparam int MOD_SHIFT = KEY_W + AW;
	localparam int PROD_W = KEY_W + 32;
	// Rounded-up reciprocal; exact quotient for every key below 2**KEY_W.
	localparam logic [31:0] RECIP =
		32'(((64'd1 << MOD_SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

	state_t state_q, state_d;

	logic [OPCODE_W-1:0]  op_q;
	logic [KEY_W-1:0]     key_q;
	logic [PROD_W-1:0]    prod_q;
	logic [AW-1:0]        rem_q;
	logic [AW-1:0]        clr_q;
	logic [AW-1:0]        ptr_q;
	logic [AW-1:0]        cnt_q;
	logic [AW-1:0]        addr_s1;
	status_t              res_status_q;
	logic [AW-1:0]        res_idx_q;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [IDX_W-1:0]     slot_index_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	slot_t             ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [SLOT_W-1:0] ram_rdata;

	slot_t         rd_slot;
	logic [AW-1:0] start_addr;
	logic [AW-1:0] quot_lo;
	logic [AW-1:0] ptr_next;
	logic          key_hit;
	logic          out_free;
	logic          probe_done;
	status_t       probe_status;
	logic [AW-1:0] probe_idx;

	lpht_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_slot    = slot_t'(ram_rdata);
	assign start_addr = POW2 ? key_q[AW-1:0] : rem_q;
	// Only the low quotient bits matter, since the remainder fits in AW bits.
	assign quot_lo    = prod_q[MOD_SHIFT +: AW];
	assign ptr_next   = (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
	assign key_hit    = (rd_slot.mark == MARK_USED) && (rd_slot.key == key_q);
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = addr_s1;
		ram_wdata    = '{mark: MARK_USED, key: key_q};
		ram_raddr    = ptr_q;
		probe_done   = 1'b0;
		probe_status = ST_MISSING;
		probe_idx    = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '{mark: MARK_FREE, key: '0};
				if (clr_q == LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (opcode)
						OP_INSERT, OP_SEARCH, OP_DELETE: state_d = POW2 ? S_ISSUE : S_DIV;
						default:                         state_d = S_DONE;
					endcase
				end
			end
			S_DIV: begin
				state_d = S_ISSUE;
			end
			S_ISSUE: begin
				ram_raddr = start_addr;
				state_d   = S_PROBE;
			end
			S_PROBE: begin
				// The read data belongs to addr_s1; the next slot is read speculatively.
				case (op_q)
					OP_INSERT: begin
						if (rd_slot.mark != MARK_USED) begin
							ram_we       = 1'b1;
							probe_done   = 1'b1;
							probe_status = ST_INSERTED;
							probe_idx    = addr_s1;
						end else if (cnt_q == LAST) begin
							probe_done   = 1'b1;
							probe_status = ST_FULL;
						end
					end
					OP_SEARCH, OP_DELETE: begin
						if (rd_slot.mark == MARK_FREE) begin
							probe_done = 1'b1;
						end else if (key_hit) begin
							probe_done = 1'b1;
							probe_idx  = addr_s1;
							if (op_q == OP_DELETE) begin
								ram_we       = 1'b1;
								ram_wdata    = '{mark: MARK_GONE, key: rd_slot.key};
								probe_status = ST_DELETED;
							end else begin
								probe_status = ST_FOUND;
							end
						end else if (cnt_q == LAST) begin
							probe_done = 1'b1;
						end
					end
					default: probe_done = 1'b1;
				endcase
				if (probe_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q         <= opcode;
					key_q        <= key;
					prod_q       <= PROD_W'(key) * PROD_W'(RECIP);
					res_status_q <= ST_MISSING;
					res_idx_q    <= '0;
				end
			end
			S_DIV: begin
				// Key minus quotient times SLOTS, kept to the slot address bits.
				rem_q <= key_q[AW-1:0] - quot_lo * SLOTS_LO;
			end
			S_ISSUE: begin
				addr_s1 <= start_addr;
				ptr_q   <= (start_addr == LAST) ? '0 : start_addr + 1'b1;
				cnt_q   <= '0;
			end
			S_PROBE: begin
				addr_s1 <= ptr_q;
				ptr_q   <= ptr_next;
				cnt_q   <= cnt_q + 1'b1;
				if (probe_done) begin
					res_status_q <= probe_status;
					res_idx_q    <= probe_idx;
				end
			end
			S_DONE: begin
				if (out_free) begin
					status_q     <= res_status_q;
					slot_index_q <= IDX_W'(res_idx_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot_index = slot_index_q;

endmodule

FILE: rtl/core/lpht_checker.sv
// Port-level checks for the linear probing hash table, bound to the top level.
// Depends on lpht_pkg and on linear_probe_hash_table_defines.svh.
`include "linear_probe_hash_table_defines.svh"

module lpht_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [lpht_pkg::STATUS_W-1:0] status,
	input logic [lpht_pkg::IDX_W-1:0]    slot_index
);

	import lpht_pkg::*;

	// A stalled result beat keeps its payload.
	`LPHT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(slot_index), "result changed while stalled")

	// Requests are served one at a time, so a request beat closes the input.
	`LPHT_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready, "input stayed open after a request beat")

	`LPHT_ASSERT_SAME(a_status_legal, clk, arst_n, out_valid, status <= ST_DELETED, "status code out of range")

	// Table full and not found carry no slot.
	`LPHT_ASSERT_SAME(a_no_slot, clk, arst_n, out_valid && (status == ST_FULL || status == ST_MISSING), slot_index == '0, "slot index set on a miss")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.slot_index(slot_index)
);

FILE: verif/linear_probe_hash_table_tb.sv
// Self-checking testbench for linear_probe_hash_table: a queued valid/ready driver
// feeds requests, and a monitor checks each result beat against a shadow table.
// Depends on lpht_pkg and the RTL of the block only.
module linear_probe_hash_table_tb;
	import lpht_pkg::*;

	localparam int SLOTS = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = SLOTS + 40;
	localparam int POOL_SIZE = 24;
	localparam int RANDOM_REQUESTS = 1080;
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;

	typedef struct {
		logic [OPCODE_W-1:0] op;
		logic [KEY_W-1:0]    key;
		int                  gap;
		bit                  drain;
	} request_t;

	typedef struct {
		status_t          st;
		logic [IDX_W-1:0] idx;
	} answer_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OPCODE_W-1:0] opcode = OP_INSERT;
	logic [KEY_W-1:0]    key = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    slot_index;

	// Shadow copy of the table contents.
	logic [KEY_W-1:0] shadow_key [SLOTS];
	mark_t            shadow_mark [SLOTS];

	request_t request_q[$];
	answer_t  answers_due[$];

	request_t staged;
	bit       have_item = 1'b0;
	int       idle_left = 0;
	logic     next_valid;

	int       stall_left = 0;
	int       result_count = 0;
	logic     next_ready;
	answer_t  due;

	int       fail_count = 0;
	int       cycle_count = 0;

	linear_probe_hash_table #(
		.SLOTS(SLOTS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.key        (key),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot_index (slot_index)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("%0t: timeout after %0d cycles", $time, cycle_count);
		$display("FAIL linear_probe_hash_table");
		$finish;
	end

	// Applies one request to the shadow table and queues the answer it must give.
	function automatic void apply_request(input logic [OPCODE_W-1:0] op,
			input logic [KEY_W-1:0] k);
		answer_t     ans;
		int unsigned base;
		int unsigned s;
		bit          hit;
		ans.st = ST_MISSING;
		ans.idx = '0;
		base = k % SLOTS;
		hit = 1'b0;
		if (op == OP_INSERT) begin
			ans.st = ST_FULL;
			for (int n = 0; n < SLOTS; n++) begin
				s = (base + n) % SLOTS;
				if (shadow_mark[s] != MARK_USED) begin
					shadow_key[s] = k;
					shadow_mark[s] = MARK_USED;
					ans.st = ST_INSERTED;
					ans.idx = s[IDX_W-1:0];
					break;
				end
			end
		end else if (op == OP_SEARCH || op == OP_DELETE) begin
			for (int n = 0; n < SLOTS; n++) begin
				s = (base + n) % SLOTS;
				if (shadow_mark[s] == MARK_FREE)
					break;
				if (shadow_mark[s] == MARK_USED && shadow_key[s] == k) begin
					hit = 1'b1;
					break;
				end
			end
			if (hit) begin
				if (op == OP_DELETE) begin
					shadow_mark[s] = MARK_GONE;
					ans.st = ST_DELETED;
				end else begin
					ans.st = ST_FOUND;
				end
				ans.idx = s[IDX_W-1:0];
			end
		end
		answers_due.push_back(ans);
	endfunction

	task automatic queue_request(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] k,
			input int gap, input bit drain);
		request_t req;
		req.op = op;
		req.key = k;
		req.gap = gap;
		req.drain = drain;
		request_q.push_back(req);
	endtask

	// Driver: a request marked drain is held back until every answer has come.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OP_INSERT;
			key <= '0;
		end else begin
			next_valid = in_valid;
			if (in_valid && in_ready) begin
				apply_request(opcode, key);
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (!have_item && request_q.size() > 0) begin
					staged = request_q.pop_front();
					have_item = 1'b1;
					idle_left = staged.gap;
				end
				if (have_item) begin
					if (idle_left > 0) begin
						idle_left--;
					end else if (!staged.drain || answers_due.size() == 0) begin
						next_valid = 1'b1;
						opcode <= staged.op;
						key <= staged.key;
						have_item = 1'b0;
					end
				end
			end
			in_valid <= next_valid;
		end
	end

	// Monitor: checks every result beat and stalls the output side at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			next_ready = out_ready;
			if (out_valid && out_ready) begin
				result_count++;
				if (answers_due.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with no request pending: status %0d slot %0d",
						$time, status, slot_index);
				end else begin
					due = answers_due.pop_front();
					if (status !== due.st) begin
						fail_count++;
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, due.st, status);
					end
					if (slot_index !== due.idx) begin
						fail_count++;
						$display("%0t: slot_index mismatch: expected %0d, actual %0d",
							$time, due.idx, slot_index);
					end
				end
				next_ready = 1'b0;
				if ((result_count % 256) >= 96 && (result_count % 256) < 224)
					stall_left = 0;
				else
					stall_left = $urandom_range(0, 14);
			end
			if (!next_ready) begin
				if (stall_left > 0)
					stall_left--;
				else
					next_ready = 1'b1;
			end
			out_ready <= next_ready;
		end
	end

	initial begin : stimulus
		logic [KEY_W-1:0]    pool [POOL_SIZE];
		logic [OPCODE_W-1:0] op;
		logic [KEY_W-1:0]    k;
		int                  r;
		int                  ins_pct;
		int                  del_pct;
		int                  gap;

		for (int s = 0; s < SLOTS; s++) begin
			shadow_key[s] = '0;
			shadow_mark[s] = MARK_FREE;
		end

		// A small pool of keys clustered on a few home slots keeps the probe chains long.
		pool[0] = '0;
		pool[1] = KEY_MAX;
		for (int i = 2; i < POOL_SIZE; i++) begin
			if (i % 4 == 0)
				k = KEY_W'($urandom() & 32'h0000_00F0);
			else
				k = KEY_W'($urandom() & 32'h7FFF_FFF0);
			if (i < 10)
				k = k | KEY_W'(3);
			else if (i < 14)
				k = k | KEY_W'(15);
			else
				k = k | KEY_W'($urandom_range(0, 15));
			pool[i] = k;
		end

		// Directed part on an empty table.
		queue_request(OP_SEARCH, KEY_W'(5), $urandom_range(0, 14), 1'b0);
		queue_request(OP_DELETE, KEY_W'(5), $urandom_range(0, 14), 1'b0);
		queue_request(OP_INSERT, KEY_W'(5), $urandom_range(0, 14), 1'b0);
		queue_request(OP_INSERT, KEY_W'(21), $urandom_range(0, 14), 1'b0);
		queue_request(OP_INSERT, KEY_W'(5), $urandom_range(0, 14), 1'b0);
		queue_request(OP_SEARCH, KEY_W'(21), $urandom_range(0, 14), 1'b0);
		queue_request(OP_SEARCH, KEY_W'(5), $urandom_range(0, 14), 1'b0);
		queue_request(OP_DELETE, KEY_W'(5), $urandom_range(0, 14), 1'b0);
		// The deleted first copy is skipped, so the duplicate further on is found.
		queue_request(OP_SEARCH, KEY_W'(5), $urandom_range(0, 14), 1'b0);
		queue_request(OP_INSERT, KEY_W'(37), $urandom_range(0, 14), 1'b0);
		queue_request(OP_INSERT, '0, $urandom_range(0, 14), 1'b0);
		queue_request(OP_SEARCH, '0, $urandom_range(0, 14), 1'b0);
		queue_request(OP_INSERT, KEY_MAX, $urandom_range(0, 14), 1'b0);
		queue_request(OP_INSERT, KEY_W'(31), $urandom_range(0, 14), 1'b0);
		queue_request(OP_SEARCH, KEY_W'(31), $urandom_range(0, 14), 1'b0);
		queue_request(OP_UNUSED, KEY_MAX, $urandom_range(0, 14), 1'b0);
		queue_request(OP_UNUSED, KEY_W'(32'h2AAA_AAAA), 0, 1'b0);
		queue_request(OP_DELETE, KEY_MAX, 0, 1'b0);
		queue_request(OP_SEARCH, KEY_MAX, 0, 1'b0);
		queue_request(OP_SEARCH, KEY_W'(32'h5555_5555), $urandom_range(0, 14), 1'b0);

		// Random part in phases that lean toward filling, toward emptying, or mix the two.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			case ((i / 150) % 3)
				0: begin
					ins_pct = 55;
					del_pct = 15;
				end
				1: begin
					ins_pct = 15;
					del_pct = 50;
				end
				default: begin
					ins_pct = 35;
					del_pct = 30;
				end
			endcase
			r = $urandom_range(0, 99);
			if (r < 4)
				op = OP_UNUSED;
			else if (r < 4 + ins_pct)
				op = OP_INSERT;
			else if (r < 4 + ins_pct + del_pct)
				op = OP_DELETE;
			else
				op = OP_SEARCH;
			if (op == OP_UNUSED || $urandom_range(0, 99) < 15)
				k = KEY_W'($urandom());
			else
				k = pool[$urandom_range(0, POOL_SIZE - 1)];
			if ((i % 256) >= 128 && (i % 256) < 192)
				gap = 0;
			else
				gap = $urandom_range(0, 14);
			queue_request(op, k, gap, (i == 0 || i == 540));
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_q.size() > 0 || have_item || in_valid || answers_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (answers_due.size() != 0) begin
			fail_count++;
			$display("%0t: %0d results never arrived", $time, answers_due.size());
		end
		if (fail_count == 0) begin
			$display("PASS linear_probe_hash_table");
		end else begin
			$display("FAIL linear_probe_hash_table");
		end
		$finish;
	end

endmodule
